// ===== rtl/rcv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv_pkg: digit-coded radix converter package
// Shared widths, constants, types and the base clamp for the converter.
// ----------------------------------------------------------------------------
package rcv_pkg;

  // value width of the coded input and coded result
  localparam int VALUE_BITS = 31;
  // width of a base register and of one digit
  localparam int BASE_BITS = 4;

  localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = '1;
  localparam logic [BASE_BITS-1:0] RADIX_TEN = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_MIN = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_MAX = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);

  // largest decimal weight that may still be multiplied by ten
  localparam logic [VALUE_BITS-1:0] WEIGHT_LIMIT = VALUE_LIMIT / VALUE_BITS'(10);

  // divider: bits retired per cycle and cycle count per division
  localparam int STEP_BITS = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_PAD_BITS = DIV_CYCLES * STEP_BITS;
  localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1_START,
    ST_P1_WAIT,
    ST_P2_START,
    ST_P2_WAIT,
    ST_FINISH
  } rcv_state_e;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [BASE_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [BASE_BITS-1:0]  remainder;
  } div_rsp_t;

  function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
    logic [BASE_BITS-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcv_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv_in_if: converter input channel
// Valid/ready channel carrying one coded input value per transfer.
// ----------------------------------------------------------------------------
interface rcv_in_if import rcv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] coded_value;

  modport source (output valid, output coded_value, input ready);
  modport sink (input valid, input coded_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcv_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv_out_if: converter result channel
// Valid/ready channel carrying one coded result and overflow flag per transfer.
// ----------------------------------------------------------------------------
interface rcv_out_if import rcv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] coded_result;
  logic                  overflow;

  modport source (output valid, output coded_result, output overflow, input ready);
  modport sink (input valid, input coded_result, input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/rcv_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv_divider: iterative small-divisor divider
// Restoring division of a value by a base of 2..10, several bits per cycle.
// ----------------------------------------------------------------------------
module rcv_divider import rcv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_PAD_BITS-1:0] work_q, work_d;
  logic [BASE_BITS-1:0]    rem_q, rem_d;
  logic [BASE_BITS-1:0]    dvsr_q, dvsr_d;

  always_comb begin
    logic [DIV_PAD_BITS-1:0] w;
    logic [BASE_BITS-1:0]    r;
    logic [BASE_BITS:0]      trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    w      = work_q;
    r      = rem_q;
    trial  = '0;
    if (busy_q) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      for (int i = 0; i < STEP_BITS; i++) begin
        trial = {r, w[DIV_PAD_BITS-1]};
        if (trial >= {1'b0, dvsr_q}) begin
          r = BASE_BITS'(trial - {1'b0, dvsr_q});
          w = {w[DIV_PAD_BITS-2:0], 1'b1};
        end else begin
          r = trial[BASE_BITS-1:0];
          w = {w[DIV_PAD_BITS-2:0], 1'b0};
        end
      end
      work_d = w;
      rem_d  = r;
      cnt_d  = cnt_q - DIV_CNT_BITS'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_BITS'(DIV_CYCLES - 1);
      work_d = DIV_PAD_BITS'(req_i.dividend);
      rem_d  = '0;
      dvsr_d = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = work_q[VALUE_BITS-1:0];
  assign rsp_o.remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/digit_coded_radix_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// digit_coded_radix_converter: decimal-coded radix converter
// Reads decimal digits as source-base digits and writes the value back as
// target-base digits coded in decimal, saturating on overflow.
// ----------------------------------------------------------------------------
// One item at a time. The input's decimal digits are peeled off least
// significant first by dividing by ten and weighted by powers of the
// source base; the value is then split into target-base digits by dividing
// by the target base, each digit placed at the next power of ten. Both
// phases share one divider that retires STEP_BITS quotient bits a cycle,
// one division per digit. in_i.ready is high only when idle; a finished
// result waits in the output register while the next item is taken.
// Bases outside 2..10 are used as the nearest bound. A result that does not
// fit VALUE_BITS bits comes out as all ones with overflow set. Base registers
// (index 0 source, 1 target, reset 10) are to be written by the user only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module digit_coded_radix_converter import rcv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [BASE_BITS-1:0]    cfg_data_i,
  rcv_in_if.sink                  in_i,
  rcv_out_if.source               out_o
);

  // control state
  rcv_state_e           state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [BASE_BITS-1:0] src_base_q, tgt_base_q;

  // datapath
  logic [VALUE_BITS-1:0] n_q, n_d;       // remaining decimal-coded input
  logic [VALUE_BITS-1:0] v_q, v_d;       // binary value
  logic [VALUE_BITS-1:0] p_q, p_d;       // source-base weight
  logic [VALUE_BITS-1:0] acc_q, acc_d;   // decimal-coded result so far
  logic [VALUE_BITS-1:0] w_q, w_d;       // decimal weight
  logic                  wbig_q, wbig_d; // weight can no longer grow
  logic                  ovf_q, ovf_d;
  logic [BASE_BITS-1:0]  sb_q, sb_d, tb_q, tb_d;
  logic [VALUE_BITS-1:0] res_q, res_d;
  logic                  res_ovf_q, res_ovf_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [VALUE_BITS+BASE_BITS-1:0] digit_term;  // digit times source weight
  logic [VALUE_BITS+BASE_BITS-1:0] p_next;
  logic [VALUE_BITS+BASE_BITS-1:0] dw;          // target digit times decimal weight
  logic [VALUE_BITS+BASE_BITS-1:0] w_next;
  logic [VALUE_BITS-1:0]           room;
  logic                            in_xfer, out_xfer;

  rcv_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  // digit arithmetic on the divider's remainder, plus the next source and decimal weights
  assign digit_term = (VALUE_BITS+BASE_BITS)'(div_rsp.remainder) *
                      (VALUE_BITS+BASE_BITS)'(p_q);
  assign p_next     = (VALUE_BITS+BASE_BITS)'(p_q) * (VALUE_BITS+BASE_BITS)'(sb_q);
  assign dw         = (VALUE_BITS+BASE_BITS)'(div_rsp.remainder) *
                      (VALUE_BITS+BASE_BITS)'(w_q);
  assign w_next     = (VALUE_BITS+BASE_BITS)'(w_q) * (VALUE_BITS+BASE_BITS)'(RADIX_TEN);
  assign room       = VALUE_LIMIT - acc_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    n_d         = n_q;
    v_d         = v_q;
    p_d         = p_q;
    acc_d       = acc_q;
    w_d         = w_q;
    wbig_d      = wbig_q;
    ovf_d       = ovf_q;
    sb_d        = sb_q;
    tb_d        = tb_q;
    res_d       = res_q;
    res_ovf_d   = res_ovf_q;
    div_req     = '{start: 1'b0, dividend: n_q, divisor: RADIX_TEN};

    // result register empties on its own transfer
    if (out_xfer) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          n_d     = in_i.coded_value;
          v_d     = '0;
          p_d     = VALUE_BITS'(1);
          acc_d   = '0;
          w_d     = VALUE_BITS'(1);
          wbig_d  = 1'b0;
          ovf_d   = 1'b0;
          sb_d    = clamp_base(src_base_q);
          tb_d    = clamp_base(tgt_base_q);
          state_d = ST_P1_START;
        end
      end
      ST_P1_START: begin
        // next decimal digit of the input, or on to the output phase
        if (n_q == '0) begin
          state_d = ST_P2_START;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_P1_WAIT;
        end
      end
      ST_P1_WAIT: begin
        if (div_rsp.done) begin
          v_d     = v_q + digit_term[VALUE_BITS-1:0];
          p_d     = p_next[VALUE_BITS-1:0];
          n_d     = div_rsp.quotient;
          state_d = ST_P1_START;
        end
      end
      ST_P2_START: begin
        div_req.dividend = v_q;
        div_req.divisor  = tb_q;
        if (v_q == '0 || ovf_q) begin
          state_d = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_P2_WAIT;
        end
      end
      ST_P2_WAIT: begin
        div_req.dividend = v_q;
        div_req.divisor  = tb_q;
        if (div_rsp.done) begin
          v_d = div_rsp.quotient;
          if (div_rsp.remainder != '0) begin
            // a nonzero digit must land on a weight that still fits
            if (wbig_q || dw > (VALUE_BITS + BASE_BITS)'(room)) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_q + dw[VALUE_BITS-1:0];
            end
          end
          if (!wbig_q) begin
            if (w_q > WEIGHT_LIMIT) wbig_d = 1'b1;
            else w_d = w_next[VALUE_BITS-1:0];
          end
          state_d = ST_P2_START;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_q || out_o.ready) begin
          res_d       = ovf_q ? VALUE_LIMIT : acc_q;
          res_ovf_d   = ovf_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // base registers, raw value kept and clamped when an item starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= BASE_RESET;
      tgt_base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_BASE: src_base_q <= cfg_data_i;
        CFG_TARGET_BASE: tgt_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    v_q       <= v_d;
    p_q       <= p_d;
    acc_q     <= acc_d;
    w_q       <= w_d;
    wbig_q    <= wbig_d;
    ovf_q     <= ovf_d;
    sb_q      <= sb_d;
    tb_q      <= tb_d;
    res_q     <= res_d;
    res_ovf_q <= res_ovf_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.coded_result = res_q;
  assign out_o.overflow     = res_ovf_q;

endmodule
`default_nettype wire

// ===== rtl/rcv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcv_checker: converter port checks
// Concurrent checks on the converter's channels, bound to the top level.
// ----------------------------------------------------------------------------
module rcv_checker import rcv_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] coded_result_i,
  input logic                  overflow_i
);

  // a result waiting for its transfer stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(coded_result_i) && $stable(overflow_i))
    else $error("stalled result changed");

  // overflow always comes with a saturated result
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> coded_result_i == VALUE_LIMIT)
    else $error("overflow without saturation");

  // one item at a time: input closes right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in work");

endmodule

bind digit_coded_radix_converter rcv_checker u_rcv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .coded_result_i (out_o.coded_result),
  .overflow_i     (out_o.overflow)
);
`default_nettype wire

// ===== dv/digit_coded_radix_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_coded_radix_converter_test: self-checking bench for the radix converter
// Sends decimal-coded values through the input channel under many base
// settings, works out every coded result and overflow flag on the side and
// compares each result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module digit_coded_radix_converter_test;
  import rcv_pkg::*;

  // generous bound on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  // settle time after the last result
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASE_COUNT = 14;

  typedef struct packed {
    logic [VALUE_BITS-1:0] coded_result;
    logic                  overflow;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [BASE_BITS-1:0]    cfg_data;

  rcv_in_if  in_ch ();
  rcv_out_if out_ch ();

  digit_coded_radix_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // bench copy of the two base registers, raw 4-bit values as written
  logic [BASE_BITS-1:0] src_base_q = BASE_BITS'(10);
  logic [BASE_BITS-1:0] tgt_base_q = BASE_BITS'(10);

  conv_result_t pending_results[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  send_gaps_on = 1'b1;
  bit  recv_stalls_on = 1'b1;
  int  stall_left = 0;

  always #2 clk_i = ~clk_i;

  // known values on every input from time zero
  initial begin
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SOURCE_BASE;
    cfg_data         = '0;
    in_ch.valid       = 1'b0;
    in_ch.coded_value = '0;
    out_ch.ready      = 1'b0;
  end

  // base actually used: anything below 2 acts as 2, above 10 acts as 10
  function automatic int usable_base(logic [BASE_BITS-1:0] raw);
    if (raw < 4'd2) return 2;
    if (raw > 4'd10) return 10;
    return int'(raw);
  endfunction

  // coded value in, coded result and overflow out, exact integer arithmetic
  function automatic conv_result_t convert_digits(logic [VALUE_BITS-1:0] coded,
                                                  logic [BASE_BITS-1:0] src_raw,
                                                  logic [BASE_BITS-1:0] tgt_raw);
    longint unsigned lim, n, value, weight, acc, dec_pos, digit, sb, tb;
    bit dec_big, sat;
    conv_result_t res;
    lim     = (64'd1 << VALUE_BITS) - 1;
    n       = 64'(coded);
    sb      = 64'(usable_base(src_raw));
    tb      = 64'(usable_base(tgt_raw));
    value   = 0;
    weight  = 1;
    acc     = 0;
    dec_pos = 1;
    dec_big = 1'b0;
    sat     = 1'b0;
    // decimal digits taken as source-base digits, no digit range check
    while (n != 0) begin
      value  += (n % 10) * weight;
      n      /= 10;
      weight *= sb;
    end
    // peel target-base digits and place each at the next power of ten
    while (value != 0 && !sat) begin
      digit  = value % tb;
      value /= tb;
      if (digit != 0) begin
        if (dec_big || digit > (lim - acc) / dec_pos) sat = 1'b1;
        else acc += digit * dec_pos;
      end
      if (!dec_big) begin
        if (dec_pos > lim / 10) dec_big = 1'b1;
        else dec_pos *= 10;
      end
    end
    res.coded_result = sat ? VALUE_LIMIT : acc[VALUE_BITS-1:0];
    res.overflow     = sat;
    return res;
  endfunction

  // random decimal string whose digits are all legal in the given base
  function automatic logic [VALUE_BITS-1:0] digits_in_base(logic [BASE_BITS-1:0] raw);
    longint unsigned acc;
    int len;
    int base;
    base = usable_base(raw);
    len  = $urandom_range(1, 10);
    acc  = 0;
    for (int i = 0; i < len; i++) acc = acc * 10 + $urandom_range(0, base - 1);
    if (acc > 64'(VALUE_LIMIT)) acc = acc / 10;
    return acc[VALUE_BITS-1:0];
  endfunction

  // mix of well-formed digit strings, raw noise, small values and near-max values
  function automatic logic [VALUE_BITS-1:0] pick_coded_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return digits_in_base(src_base_q);
    if (sel <= 7) return VALUE_BITS'($urandom);
    if (sel == 8) return VALUE_BITS'($urandom_range(0, 99));
    return VALUE_LIMIT - VALUE_BITS'($urandom_range(0, 1000));
  endfunction

  // result side: ready held low in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker: each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected result: expected none, actual %0d overflow %0b",
                 $time, out_ch.coded_result, out_ch.overflow);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.coded_result !== want.coded_result) begin
          error_count++;
          $display("%0t coded_result mismatch: expected %0d, actual %0d",
                   $time, want.coded_result, out_ch.coded_result);
        end
        if (out_ch.overflow !== want.overflow) begin
          error_count++;
          $display("%0t overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, out_ch.overflow);
        end
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[digit_coded_radix_converter] ERROR");
      $finish;
    end
  end

  // one input transfer; valid is left high so back-to-back items need no toggle
  task automatic send_coded(logic [VALUE_BITS-1:0] coded);
    if (send_gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.coded_value <= coded;
    do @(posedge clk_i); while (!in_ch.ready);
    // transfer taken at this edge, predict with the bases in force now
    pending_results.push_back(convert_digits(coded, src_base_q, tgt_base_q));
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // both base registers, written only with the block idle
  task automatic write_bases(logic [BASE_BITS-1:0] src, logic [BASE_BITS-1:0] tgt);
    wait_results_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SOURCE_BASE;
    cfg_data <= src;
    @(posedge clk_i);
    src_base_q = src;
    cfg_idx  <= CFG_TARGET_BASE;
    cfg_data <= tgt;
    @(posedge clk_i);
    tgt_base_q = tgt;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset bases are ten and ten, so values pass through unchanged
  task automatic test_reset_bases();
    send_coded('0);
    send_coded(VALUE_BITS'(1));
    send_coded(VALUE_LIMIT);
    send_coded(VALUE_BITS'(1234567890));
  endtask

  // register values outside 2..10 act as the nearest bound
  task automatic test_base_clamp();
    write_bases(4'd0, 4'd15);
    send_coded(VALUE_BITS'(101101));
    write_bases(4'd1, 4'd11);
    send_coded(VALUE_BITS'(987654321));
    write_bases(4'd15, 4'd0);
    send_coded(VALUE_BITS'(255));
    send_coded(VALUE_LIMIT);
  endtask

  // digits above the source base, widest values and saturation
  task automatic test_digits_and_overflow();
    write_bases(4'd2, 4'd10);
    send_coded(VALUE_BITS'(1111111111));
    send_coded(VALUE_BITS'(999999999));
    send_coded(VALUE_LIMIT);
    write_bases(4'd10, 4'd2);
    send_coded(VALUE_BITS'(1023));
    send_coded(VALUE_BITS'(1024));
    send_coded(VALUE_LIMIT);
    send_coded('0);
    write_bases(4'd9, 4'd9);
    send_coded(VALUE_BITS'(88888888));
    write_bases(4'd2, 4'd2);
    send_coded(VALUE_BITS'(1010101010));
  endtask

  // sender holds off until everything in flight has come back
  task automatic test_sender_pause();
    write_bases(4'd10, 4'd3);
    send_coded(VALUE_BITS'(26));
    send_coded(VALUE_BITS'(27));
    wait_results_drained();
    send_coded(VALUE_BITS'(59048));
    send_coded(VALUE_BITS'(59049));
  endtask

  // random phases: extreme base pairs first, then any register value
  task automatic test_random_phases();
    logic [BASE_BITS-1:0] src, tgt;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin src = 4'd2;  tgt = 4'd2;  end
        1: begin src = 4'd10; tgt = 4'd10; end
        2: begin src = 4'd2;  tgt = 4'd10; end
        3: begin src = 4'd10; tgt = 4'd2;  end
        default: begin
          src = BASE_BITS'($urandom_range(0, 15));
          tgt = BASE_BITS'($urandom_range(0, 15));
        end
      endcase
      write_bases(src, tgt);
      // the last two phases run flat out on both sides
      if (ph >= PHASE_COUNT - 2) begin
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
      end else begin
        send_gaps_on   = ($urandom_range(0, 3) != 0);
        recv_stalls_on = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_coded(pick_coded_value());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_bases();
    test_base_clamp();
    test_digits_and_overflow();
    test_sender_pause();
    test_random_phases();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t results left over: expected 0, actual %0d",
               $time, pending_results.size());
    end
    if (error_count == 0) begin
      $display("[digit_coded_radix_converter] OK");
    end else begin
      $display("[digit_coded_radix_converter] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rcv_pkg.sv
rtl/rcv_in_if.sv
rtl/rcv_out_if.sv
rtl/rcv_divider.sv
rtl/digit_coded_radix_converter.sv
rtl/rcv_checker.sv
dv/digit_coded_radix_converter_test.sv
